@@ rtl/lupp_pkg.sv @@
// ----------------------------------------------------------------------------
// lupp_pkg
// shared types and constants of the lu decomposition block
// ----------------------------------------------------------------------------
package lupp_pkg;

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 3;
  localparam int SIZE_W     = 4;
  localparam int Q_FRAC     = 24;
  localparam int SIZE_RESET = 8;

  // register indexes of the configuration port
  localparam int REG_MATRIX_SIZE = 0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PIV_INIT,
    OP_PIV_RD,
    OP_PIV_CMP,
    OP_SWAP,
    OP_M_RD,
    OP_DIV_GO,
    OP_M_WR,
    OP_U_RD,
    OP_MUL,
    OP_U_WR,
    OP_OUT_RD,
    OP_CLEAR
  } dp_op_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PINIT,
    S_PRD,
    S_PCMP,
    S_SWAP,
    S_MRD,
    S_DIV,
    S_DWAIT,
    S_MWR,
    S_URD,
    S_UMUL,
    S_UWR,
    S_ORD,
    S_CLR
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } stat_t;

endpackage

@@ rtl/lupp_ram.sv @@
// ----------------------------------------------------------------------------
// lupp_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module lupp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/lupp_div.sv @@
// ----------------------------------------------------------------------------
// lupp_div
// restoring divider, one quotient bit per cycle, result (a * 2^24) / p
// truncated toward zero and saturated to 32 bits
// ----------------------------------------------------------------------------
module lupp_div
  import lupp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] p,
  output logic                     busy,
  output logic signed [DATA_W-1:0] q
);

  localparam int STEPS = DATA_W + Q_FRAC;
  localparam int CW    = $clog2(STEPS + 1);

  logic [DATA_W-1:0] dv;
  logic [DATA_W-1:0] rem;
  logic [STEPS-1:0]  quo;
  logic [CW-1:0]     cnt;
  logic              neg;

  logic [DATA_W-1:0] a_mag;
  logic [DATA_W-1:0] p_mag;
  logic [DATA_W:0]   trial;
  logic              ge;

  assign a_mag = a[DATA_W-1] ? (~a + 1'b1) : a;
  assign p_mag = p[DATA_W-1] ? (~p + 1'b1) : p;
  assign trial = {rem, quo[STEPS-1]};
  assign ge    = trial >= {1'b0, dv};
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (go) begin
      cnt <= CW'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dv  <= p_mag;
      quo <= {a_mag, {Q_FRAC{1'b0}}};
      rem <= '0;
      neg <= a[DATA_W-1] ^ p[DATA_W-1];
    end else if (busy) begin
      rem <= ge ? DATA_W'(trial - {1'b0, dv}) : trial[DATA_W-1:0];
      quo <= {quo[STEPS-2:0], ge};
    end
  end

  // sign and saturation of the magnitude quotient
  always_comb begin
    if (neg) begin
      if (quo > STEPS'(64'h8000_0000)) begin
        q = 32'sh8000_0000;
      end else begin
        q = ~quo[DATA_W-1:0] + 1'b1;
      end
    end else begin
      if (quo > STEPS'(64'h7fff_ffff)) begin
        q = 32'sh7fff_ffff;
      end else begin
        q = quo[DATA_W-1:0];
      end
    end
  end

endmodule

@@ rtl/lupp_datapath.sv @@
// ----------------------------------------------------------------------------
// lupp_datapath
// matrix store, row permutation, pivot search, divider, multiply-subtract
// and result registers
// ----------------------------------------------------------------------------
module lupp_datapath
  import lupp_pkg::*;
#(
  parameter int MAX_N = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic signed [DATA_W-1:0] element_value,
  output stat_t                    stat,
  output logic                     done,
  output logic signed [DATA_W-1:0] lu_value,
  output logic [IDX_W-1:0]         row_index,
  output logic [IDX_W-1:0]         column_index,
  output logic [IDX_W-1:0]         source_row,
  output logic                     singular,
  output logic                     last
);

  localparam int IW    = $clog2(MAX_N);
  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] at(input logic [IW-1:0] r, input logic [IW-1:0] c);
    at = AW'(int'(r) * MAX_N + int'(c));
  endfunction

  logic [IW-1:0] ro [MAX_N];
  logic [IW-1:0] ki, ii, jj;

  assign ki = cmd.k[IW-1:0];
  assign ii = cmd.i[IW-1:0];
  assign jj = cmd.j[IW-1:0];

  // ram
  logic              we;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] wdata, rd_a, rd_b;

  lupp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // pivot search
  logic [DATA_W:0]          best;
  logic [IW-1:0]            piv;
  logic signed [DATA_W-1:0] pval;
  logic [DATA_W:0]          sv, mag;
  logic                     sing;

  assign sv  = {rd_a[DATA_W-1], rd_a};
  assign mag = rd_a[DATA_W-1] ? ((DATA_W+1)'(0) - sv) : sv;

  // divider
  logic                     div_go, div_busy, mzero;
  logic signed [DATA_W-1:0] div_q, mult;

  assign div_go = (cmd.op == OP_DIV_GO) && (pval != '0);
  assign mult   = mzero ? '0 : div_q;

  lupp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .a    (rd_a),
    .p    (pval),
    .busy (div_busy),
    .q    (div_q)
  );

  assign stat.div_busy = div_busy;

  // multiply-subtract
  logic signed [2*DATA_W-1:0] prod, prod_adj;
  logic signed [DATA_W-1:0]   x_q;
  logic signed [DATA_W+8:0]   diff;
  logic signed [DATA_W-1:0]   upd;

  always_comb begin
    // truncate toward zero before dropping the fraction bits
    prod_adj = prod + (prod[2*DATA_W-1] ? 64'sd16777215 : 64'sd0);
    diff     = (DATA_W+9)'(x_q) - (DATA_W+9)'($signed(prod_adj[2*DATA_W-1:Q_FRAC]));
    if (diff > (DATA_W+9)'(32'sh7fff_ffff)) begin
      upd = 32'sh7fff_ffff;
    end else if (diff < -(DATA_W+9)'(64'sh8000_0000)) begin
      upd = 32'sh8000_0000;
    end else begin
      upd = diff[DATA_W-1:0];
    end
  end

  // ram address and write selection
  always_comb begin
    we      = 1'b0;
    waddr   = at(ro[ii], ki);
    wdata   = mult;
    raddr_a = at(ro[ii], ki);
    raddr_b = at(ro[ii], jj);
    case (cmd.op)
      OP_LOAD: begin
        we    = 1'b1;
        waddr = at(ii, jj);
        wdata = element_value;
      end
      OP_M_WR: begin
        we = 1'b1;
      end
      OP_U_RD: begin
        raddr_a = at(ro[ki], jj);
      end
      OP_U_WR: begin
        we    = 1'b1;
        waddr = at(ro[ii], jj);
        wdata = upd;
      end
      OP_OUT_RD: begin
        raddr_a = at(ro[ii], jj);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_N; r++) begin
        ro[r] <= IW'(r);
      end
      sing <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= cmd.op == OP_OUT_RD;
      case (cmd.op)
        OP_SWAP: begin
          if (best == '0) begin
            sing <= 1'b1;
          end
          if (piv != ki) begin
            ro[ki]  <= ro[piv];
            ro[piv] <= ro[ki];
          end
        end
        OP_CLEAR: begin
          for (int r = 0; r < MAX_N; r++) begin
            ro[r] <= IW'(r);
          end
          sing <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PIV_INIT: begin
        best <= '0;
        piv  <= ki;
        pval <= '0;
      end
      OP_PIV_CMP: begin
        // strictly greater, so the first row wins a tie
        if (mag > best) begin
          best <= mag;
          piv  <= ii;
          pval <= rd_a;
        end
      end
      OP_DIV_GO: begin
        mzero <= pval == '0;
      end
      OP_MUL: begin
        prod <= mult * $signed(rd_a);
        x_q  <= rd_b;
      end
      OP_OUT_RD: begin
        row_index    <= cmd.i;
        column_index <= cmd.j;
        source_row   <= IDX_W'(ro[ii]);
        singular     <= sing;
        last         <= cmd.last;
      end
      default: begin
      end
    endcase
  end

  assign lu_value = rd_a;

endmodule

@@ rtl/lupp_ctrl.sv @@
// ----------------------------------------------------------------------------
// lupp_ctrl
// sequencer for load, pivot search, elimination and emission
// ----------------------------------------------------------------------------
module lupp_ctrl
  import lupp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             cfg_wr,
  input  logic [IDX_W-1:0] nm1,
  input  stat_t            stat,
  output logic             busy,
  output cmd_t             cmd
);

  ctrl_state_t      state, state_next;
  logic [IDX_W-1:0] k, i, j, lr, lc;
  logic [IDX_W-1:0] k_next, i_next, j_next, lr_next, lc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      k     <= '0;
      i     <= '0;
      j     <= '0;
      lr    <= '0;
      lc    <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      i     <= i_next;
      j     <= j_next;
      lr    <= lr_next;
      lc    <= lc_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    i_next     = i;
    j_next     = j;
    lr_next    = lr;
    lc_next    = lc;
    cmd.op     = OP_NONE;
    cmd.k      = k;
    cmd.i      = i;
    cmd.j      = j;
    cmd.last   = 1'b0;
    case (state)
      S_LOAD: begin
        cmd.i = lr;
        cmd.j = lc;
        if (start) begin
          cmd.op = OP_LOAD;
          if (lc == nm1) begin
            lc_next = '0;
            if (lr == nm1) begin
              lr_next    = '0;
              k_next     = '0;
              state_next = S_PINIT;
            end else begin
              lr_next = lr + 1'b1;
            end
          end else begin
            lc_next = lc + 1'b1;
          end
        end
      end
      S_PINIT: begin
        cmd.op     = OP_PIV_INIT;
        i_next     = k;
        state_next = S_PRD;
      end
      S_PRD: begin
        cmd.op     = OP_PIV_RD;
        state_next = S_PCMP;
      end
      S_PCMP: begin
        cmd.op = OP_PIV_CMP;
        if (i == nm1) begin
          state_next = S_SWAP;
        end else begin
          i_next     = i + 1'b1;
          state_next = S_PRD;
        end
      end
      S_SWAP: begin
        cmd.op = OP_SWAP;
        if (k == nm1) begin
          i_next     = '0;
          j_next     = '0;
          state_next = S_ORD;
        end else begin
          i_next     = k + 1'b1;
          state_next = S_MRD;
        end
      end
      S_MRD: begin
        cmd.op     = OP_M_RD;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op     = OP_DIV_GO;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat.div_busy) begin
          state_next = S_MWR;
        end
      end
      S_MWR: begin
        cmd.op     = OP_M_WR;
        j_next     = k + 1'b1;
        state_next = S_URD;
      end
      S_URD: begin
        cmd.op     = OP_U_RD;
        state_next = S_UMUL;
      end
      S_UMUL: begin
        cmd.op     = OP_MUL;
        state_next = S_UWR;
      end
      S_UWR: begin
        cmd.op = OP_U_WR;
        if (j == nm1) begin
          if (i == nm1) begin
            k_next     = k + 1'b1;
            state_next = S_PINIT;
          end else begin
            i_next     = i + 1'b1;
            state_next = S_MRD;
          end
        end else begin
          j_next     = j + 1'b1;
          state_next = S_URD;
        end
      end
      S_ORD: begin
        cmd.op   = OP_OUT_RD;
        cmd.last = (i == nm1) && (j == nm1);
        if (j == nm1) begin
          j_next = '0;
          if (i == nm1) begin
            state_next = S_CLR;
          end else begin
            i_next = i + 1'b1;
          end
        end else begin
          j_next = j + 1'b1;
        end
      end
      S_CLR: begin
        cmd.op     = OP_CLEAR;
        state_next = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
    // a size write restarts loading
    if (cfg_wr) begin
      lr_next = '0;
      lc_next = '0;
    end
  end

  assign busy = state != S_LOAD;

endmodule

@@ rtl/lu_decompose_partial_pivot.sv @@
// ----------------------------------------------------------------------------
// lu_decompose_partial_pivot
// lu decomposition with partial pivoting of an n x n q8.24 matrix
//
//   channel   signals                                      handshake
//   input     element_value                                start & !busy
//   result    lu_value row_index column_index source_row   done, one cycle
//             singular last
//   config    psel penable pwrite paddr pwdata prdata      apb, pready high
//
// loading takes one element beat per cycle while start is high. after the
// last element the block is busy: per column a pivot search that reads and
// compares each row from row k down, then per row below a division on the
// one-bit-per-cycle divider (56 steps), and per updated element a read, a
// multiply and a write on the shared multiplier and the two read ports of
// the matrix ram; then n*n result beats, one per cycle, and a clear state.
// reset is synchronous; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module lu_decompose_partial_pivot
  import lupp_pkg::*;
#(
  parameter int MAX_N = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] element_value,
  output logic                     done,
  output logic signed [DATA_W-1:0] lu_value,
  output logic [IDX_W-1:0]         row_index,
  output logic [IDX_W-1:0]         column_index,
  output logic [IDX_W-1:0]         source_row,
  output logic                     singular,
  output logic                     last,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [SIZE_W-1:0] matrix_size;
  logic [IDX_W-1:0]  nm1;
  logic              cfg_wr;
  cmd_t              cmd;
  stat_t             stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 3'(REG_MATRIX_SIZE * 4));
  assign prdata = (paddr == 3'(REG_MATRIX_SIZE * 4)) ? 32'(matrix_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_W'(SIZE_RESET);
    end else if (cfg_wr) begin
      matrix_size <= pwdata[SIZE_W-1:0];
    end
  end

  // size 0 acts as 1, above the maximum acts as the maximum
  always_comb begin
    if (matrix_size == '0) begin
      nm1 = '0;
    end else if (matrix_size > SIZE_W'(MAX_N)) begin
      nm1 = IDX_W'(MAX_N - 1);
    end else begin
      nm1 = IDX_W'(matrix_size - 1'b1);
    end
  end

  lupp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_wr (cfg_wr),
    .nm1    (nm1),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  lupp_datapath #(.MAX_N(MAX_N)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .element_value (element_value),
    .stat          (stat),
    .done          (done),
    .lu_value      (lu_value),
    .row_index     (row_index),
    .column_index  (column_index),
    .source_row    (source_row),
    .singular      (singular),
    .last          (last)
  );

endmodule
